// ===== src/card_number_validator_macros.svh =====
`ifndef CARD_NUMBER_VALIDATOR_MACROS_SVH
`define CARD_NUMBER_VALIDATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define CNV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cnv assertion failed");

// next-cycle implication, disabled in reset
`define CNV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cnv assertion failed");

`endif

// ===== src/cnv_pkg.sv =====
package cnv_pkg;

    typedef logic [1:0] t_status;
    typedef logic [2:0] t_kind;
    typedef logic [4:0] t_count;
    typedef logic [3:0] t_digit;

    localparam t_count MIN_LEN   = 5'd13;
    localparam t_count MAX_LEN   = 5'd19;
    localparam t_count COUNT_SAT = 5'd20;

    localparam t_status ST_VALID   = 2'd0;
    localparam t_status ST_BAD_LEN = 2'd1;
    localparam t_status ST_NON_DIG = 2'd2;
    localparam t_status ST_LUHN    = 2'd3;

    localparam t_kind KIND_VISA   = 3'd0;
    localparam t_kind KIND_MASTER = 3'd1;
    localparam t_kind KIND_MAESTR = 3'd2;
    localparam t_kind KIND_JCB    = 3'd3;
    localparam t_kind KIND_AMEX   = 3'd4;
    localparam t_kind KIND_OTHER  = 3'd5;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;

    function automatic logic is_blank(input logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // Luhn doubling: 2d, minus 9 when above 9
    function automatic t_digit dbl_digit(input t_digit d);
        logic [4:0] t;
        t = {d, 1'b0};
        if (t > 5'd9) begin
            t = t - 5'd9;
        end
        return t[3:0];
    endfunction

    // both operands below 10
    function automatic t_digit add_mod10(input t_digit a, input t_digit b);
        logic [4:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 5'd10) begin
            s = s - 5'd10;
        end
        return s[3:0];
    endfunction

    function automatic t_kind kind_of(input logic [7:0] a, input logic [7:0] b);
        t_kind k;
        priority if (a == CH_3) begin
            k = ((b == CH_4) || (b == CH_7)) ? KIND_AMEX : KIND_JCB;
        end else if (a == CH_4) begin
            k = KIND_VISA;
        end else if (a == CH_5) begin
            k = KIND_MASTER;
        end else if (a == CH_6) begin
            k = KIND_MAESTR;
        end else begin
            k = KIND_OTHER;
        end
        return k;
    endfunction

endpackage

// ===== src/cnv_if.sv =====
interface cnv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface cnv_res_if import cnv_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    t_kind   card_kind;

    modport source (output valid, output status, output card_kind, input ready);
    modport sink   (input valid, input status, input card_kind, output ready);
endinterface

// ===== src/card_number_validator.sv =====
// Card number check, Luhn mod 10 plus issuer class.
// Input channel i_char_ch: one character per item, is_last on the final one.
//   Whitespace (codes 9..13, 32) is dropped but an is_last on it still closes
//   the number.
// Output channel o_res_ch: one item per number, status and card_kind.
// Throughput: one character per cycle except in a stall (below), including back
//   to back numbers; the per-character update is two 4-bit mod-10 adds and a compare.
// Path: the last character is registered in the input register, and the state
//   update from it is registered into the result register.
// Stall: while a result waits on o_res_ch, the input register still drains
//   characters that do not close a number; a closing character waits in the
//   input register, and i_char_ch.ready drops only once that register is
//   full and cannot move.
// Reset: synchronous, active low; clears both valid flags and all running
//   state, so the first item after reset starts a new number.
`include "card_number_validator_macros.svh"

module card_number_validator import cnv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cnv_in_if.sink     i_char_ch,
    cnv_res_if.source  o_res_ch
);

    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_last;

    t_count     r_count,  n_count;
    logic       r_non,    n_non;
    t_digit     r_plain,  n_plain;
    t_digit     r_dbl,    n_dbl;
    logic [7:0] r_first,  n_first;
    logic [7:0] r_second, n_second;

    logic       r_out_valid;
    t_status    r_status, n_status;
    t_kind      r_kind;

    logic       w_move;
    logic       w_step;
    logic       w_in_ready;
    t_digit     w_digit;

    assign w_move     = !r_out_valid || o_res_ch.ready || !r_last;
    assign w_step     = r_in_valid && w_move;
    assign w_in_ready = !r_in_valid || w_move;
    assign w_digit    = r_char[3:0];

    assign i_char_ch.ready    = w_in_ready;
    assign o_res_ch.valid     = r_out_valid;
    assign o_res_ch.status    = r_status;
    assign o_res_ch.card_kind = r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_char_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_char_ch.valid) begin
            r_char <= i_char_ch.char_code;
            r_last <= i_char_ch.is_last;
        end
    end

    always_comb begin
        n_count  = r_count;
        n_non    = r_non;
        n_plain  = r_plain;
        n_dbl    = r_dbl;
        n_first  = r_first;
        n_second = r_second;
        if (!is_blank(r_char)) begin
            priority if (r_count == '0) begin
                n_first = r_char;
            end else if (r_count == 5'd1) begin
                n_second = r_char;
            end else begin
            end
            if (r_count < COUNT_SAT) begin
                n_count = r_count + 5'd1;
            end
            if (is_digit(r_char)) begin
                n_plain = add_mod10(r_dbl, w_digit);
                n_dbl   = add_mod10(r_plain, dbl_digit(w_digit));
            end else begin
                n_non = 1'b1;
            end
        end
    end

    always_comb begin
        priority if ((n_count < MIN_LEN) || (n_count > MAX_LEN)) begin
            n_status = ST_BAD_LEN;
        end else if (n_non) begin
            n_status = ST_NON_DIG;
        end else if (n_plain != '0) begin
            n_status = ST_LUHN;
        end else begin
            n_status = ST_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_step && r_last)) begin
            r_count  <= '0;
            r_non    <= 1'b0;
            r_plain  <= '0;
            r_dbl    <= '0;
            r_first  <= '0;
            r_second <= '0;
        end else if (w_step) begin
            r_count  <= n_count;
            r_non    <= n_non;
            r_plain  <= n_plain;
            r_dbl    <= n_dbl;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_last) begin
            r_status <= n_status;
            r_kind   <= kind_of(n_first, n_second);
        end
    end

    `CNV_ASSERT_NOW(a_sums_mod10, 1'b1, (r_plain < 4'd10) && (r_dbl < 4'd10))
    `CNV_ASSERT_NEXT(a_clear_after_last, w_step && r_last, (r_count == '0) && !r_non)
    `CNV_ASSERT_NOW(a_res_from_last, $rose(r_out_valid), $past(r_in_valid && r_last))
    `CNV_ASSERT_NOW(a_stall_cause, !w_in_ready,
                    r_in_valid && r_last && r_out_valid && !o_res_ch.ready)

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import cnv_pkg::*;

    typedef struct packed {
        t_status status;
        t_kind   card_kind;
    } t_verdict;

    typedef struct {
        logic [7:0] code;
        logic       is_end;
        bit         typed;
        t_status    status;
        t_kind      card_kind;
    } t_demo_row;

    localparam int NUM_DEMO   = 23;
    localparam int HOLD_TICKS = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cnv_in_if  char_ch ();
    cnv_res_if res_ch ();

    card_number_validator u_top (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_char_ch (char_ch),
        .o_res_ch  (res_ch)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // running state of the number being checked
    t_count     n_kept;
    bit         any_non_digit;
    t_digit     luhn_if_plain;
    t_digit     luhn_if_doubled;
    logic [7:0] lead_a;
    logic [7:0] lead_b;

    t_verdict pending_verdicts[$];
    int       fail_count = 0;
    int       src_idle = 30;
    int       snk_idle = 80;
    logic     hold_off = 1'b0;
    bit       start_hold = 1'b0;
    int       kept_sent = 0;
    int       numbers_sent = 0;

    t_demo_row demo_rows[NUM_DEMO] = '{
        '{CH_SPACE, 1'b1, 1'b1, ST_BAD_LEN, KIND_OTHER},
        '{CH_3,     1'b1, 1'b1, ST_BAD_LEN, KIND_JCB},
        '{8'hFF,    1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{8'h00,    1'b1, 1'b1, ST_BAD_LEN, KIND_OTHER},
        '{CH_3,     1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{CH_7,     1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{8'h38,    1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{8'h32,    1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{CH_TAB,   1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{8'h38,    1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{8'h32,    1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{8'h32,    1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{CH_4,     1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{CH_6,     1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{CH_3,     1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{8'h31,    1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{CH_0,     1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{CH_0,     1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{CH_0,     1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{CH_5,     1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{CH_SPACE, 1'b1, 1'b0, ST_VALID,   KIND_VISA},
        '{CH_5,     1'b0, 1'b0, ST_VALID,   KIND_VISA},
        '{8'h41,    1'b1, 1'b1, ST_BAD_LEN, KIND_MASTER}
    };

    function automatic bit is_space_code(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_decimal(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic t_kind issuer_of(input logic [7:0] a, input logic [7:0] b);
        case (a)
            CH_3:    return (b == CH_4 || b == CH_7) ? KIND_AMEX : KIND_JCB;
            CH_4:    return KIND_VISA;
            CH_5:    return KIND_MASTER;
            CH_6:    return KIND_MAESTR;
            default: return KIND_OTHER;
        endcase
    endfunction

    function automatic void clear_number();
        n_kept          = '0;
        any_non_digit   = 1'b0;
        luhn_if_plain   = '0;
        luhn_if_doubled = '0;
        lead_a          = '0;
        lead_b          = '0;
    endfunction

    // returns 1 when the character closes a number, with its verdict
    function automatic bit absorb_char(input logic [7:0] c, input logic is_end,
                                       output t_verdict v);
        int d;
        int d2;
        int np;
        int nd;
        v = '0;
        if (!is_space_code(c)) begin
            if (n_kept == 0) begin
                lead_a = c;
            end else if (n_kept == 1) begin
                lead_b = c;
            end
            if (n_kept < COUNT_SAT) begin
                n_kept = n_kept + 1'b1;
            end
            if (is_decimal(c)) begin
                d  = int'(c) - int'(CH_0);
                d2 = (d < 5) ? 2 * d : 2 * d - 9;
                np = (int'(luhn_if_doubled) + d) % 10;
                nd = (int'(luhn_if_plain) + d2) % 10;
                luhn_if_plain   = t_digit'(np);
                luhn_if_doubled = t_digit'(nd);
            end else begin
                any_non_digit = 1'b1;
            end
        end
        if (!is_end) begin
            return 1'b0;
        end
        if (n_kept < MIN_LEN || n_kept > MAX_LEN) begin
            v.status = ST_BAD_LEN;
        end else if (any_non_digit) begin
            v.status = ST_NON_DIG;
        end else if (luhn_if_plain != 0) begin
            v.status = ST_LUHN;
        end else begin
            v.status = ST_VALID;
        end
        v.card_kind = issuer_of(lead_a, lead_b);
        clear_number();
        return 1'b1;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic is_end,
                             input bit typed, input t_verdict typed_v);
        t_verdict v;
        while ($urandom_range(0, 99) < src_idle) begin
            char_ch.valid <= 1'b0;
            @(posedge clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        char_ch.is_last   <= is_end;
        @(posedge clk);
        while (!char_ch.ready) begin
            @(posedge clk);
        end
        if (!is_space_code(c)) begin
            kept_sent++;
        end
        if (absorb_char(c, is_end, v)) begin
            pending_verdicts.push_back(typed ? typed_v : v);
            numbers_sent++;
        end
    endtask

    function automatic int luhn_tail(input int body[$]);
        int s;
        int d;
        int k;
        s = 0;
        k = 0;
        for (int i = body.size() - 1; i >= 0; i--) begin
            d = body[i];
            if (k % 2 == 0) begin
                d = (d < 5) ? 2 * d : 2 * d - 9;
            end
            s += d;
            k++;
        end
        return (10 - s % 10) % 10;
    endfunction

    function automatic logic [7:0] any_blank();
        int b;
        b = $urandom_range(0, 5);
        return (b == 5) ? CH_SPACE : CH_TAB + 8'(b);
    endfunction

    task automatic send_number();
        int         digits[$];
        logic [7:0] chars[$];
        int         mode;
        int         len;
        int         pick;
        logic [7:0] junk;
        t_verdict   none;
        none = '0;
        mode = $urandom_range(0, 99);
        if (mode >= 90) begin
            len = $urandom_range(1, 24);
            repeat (len) chars.push_back(8'($urandom_range(0, 255)));
        end else begin
            len = (mode >= 75) ? $urandom_range(0, 25) : $urandom_range(13, 19);
            pick = $urandom_range(0, 7);
            case (pick)
                0: digits = '{3, 4};
                1: digits = '{3, 7};
                2: digits = '{3, $urandom_range(0, 9)};
                3: digits = '{4};
                4: digits = '{5};
                5: digits = '{6};
                6: digits = '{$urandom_range(0, 9)};
                default: digits = '{$urandom_range(7, 9)};
            endcase
            while (digits.size() > len) void'(digits.pop_back());
            while (digits.size() < len - 1) digits.push_back($urandom_range(0, 9));
            if (digits.size() < len) begin
                digits.push_back(($urandom_range(0, 99) < 70) ? luhn_tail(digits)
                                                              : $urandom_range(0, 9));
            end
            foreach (digits[i]) begin
                chars.push_back(CH_0 + 8'(digits[i]));
                if ($urandom_range(0, 99) < 10) begin
                    chars.push_back(any_blank());
                end
            end
            if (mode >= 60 && mode < 75) begin
                do begin
                    junk = 8'($urandom_range(0, 255));
                end while (is_decimal(junk) || is_space_code(junk));
                chars.insert($urandom_range(0, chars.size()), junk);
            end
            if (chars.size() == 0 || $urandom_range(0, 99) < 10) begin
                chars.push_back(any_blank());
            end
        end
        foreach (chars[i]) begin
            send_char(chars[i], i == chars.size() - 1, 1'b0, none);
        end
    endtask

    // result side
    always @(posedge clk) begin
        res_ch.ready <= !hold_off && ($urandom_range(0, 99) >= snk_idle);
    end

    initial begin
        wait (start_hold);
        @(posedge clk);
        hold_off <= 1'b1;
        for (int n = 0; n < HOLD_TICKS; n++) begin
            @(posedge clk);
        end
        hold_off <= 1'b0;
    end

    always @(posedge clk) begin
        t_verdict want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result item with nothing pending: status %0d card_kind %0d",
                       res_ch.status, res_ch.card_kind);
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (res_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, res_ch.status);
                    fail_count++;
                end
                if (res_ch.card_kind !== want.card_kind) begin
                    $error("card_kind: expected %0d, actual %0d",
                           want.card_kind, res_ch.card_kind);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_verdict tv;
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        char_ch.is_last   = 1'b0;
        res_ch.ready      = 1'b0;
        clear_number();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (demo_rows[i]) begin
            tv.status    = demo_rows[i].status;
            tv.card_kind = demo_rows[i].card_kind;
            send_char(demo_rows[i].code, demo_rows[i].is_end, demo_rows[i].typed, tv);
        end

        while (kept_sent < 600 || numbers_sent < 30) begin
            if (kept_sent < 220) begin
                src_idle = 30;
                snk_idle = 80;
            end else if (kept_sent < 420) begin
                src_idle = 80;
                snk_idle = 30;
            end else begin
                src_idle = 0;
                snk_idle = 0;
                start_hold = 1'b1;
            end
            send_number();
        end
        char_ch.valid <= 1'b0;

        while (pending_verdicts.size() != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_verdicts.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
